@@ hdl/stss_pkg.sv @@
package stss_pkg;

	// width of the position field on the result ports
	localparam int POS_W = 9;

	// action codes carried by an input transaction
	typedef enum logic [2:0] {
		ACT_CLEAR   = 3'd0,
		ACT_APPEND  = 3'd1,
		ACT_SORT    = 3'd2,
		ACT_LSEARCH = 3'd3,
		ACT_BSEARCH = 3'd4
	} action_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_S_OUTER,
		ST_S_IWAIT,
		ST_S_JCHK,
		ST_S_JCMP,
		ST_S_SWAP1,
		ST_S_SWAP2,
		ST_L_CHK,
		ST_L_CMP,
		ST_B_CHK,
		ST_B_CMP,
		ST_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic clear;
		logic append;
		logic rd_outer;
		logic init_inner;
		logic rd_inner;
		logic cmp_inner;
		logic wr_swap1;
		logic wr_swap2;
		logic next_outer;
		logic rd_lin;
		logic cmp_lin;
		logic rd_bin;
		logic cmp_bin;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic outer_go;
		logic inner_go;
		logic need_swap;
		logic lin_go;
		logic lin_hit;
		logic bin_go;
		logic bin_hit;
	} stat_t;

endpackage

@@ hdl/stss_datapath.sv @@
module stss_datapath import stss_pkg::*; #(
	parameter int TABLE_DEPTH = 256,
	parameter int KEY_WIDTH   = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic signed [31:0] search_key,
	output stat_t              stat,
	output logic [POS_W-1:0]   position,
	output logic               found,
	output logic               status
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int BND_W = CNT_W + 1;

	// key table, one write and one registered read port
	logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
	logic [KEY_WIDTH-1:0] rd_data_q;

	logic [63:0]          key_ext;
	logic [KEY_WIDTH-1:0] key_in;
	logic [KEY_WIDTH-1:0] key_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     i_q, j_q, p_q, best_q, mid_q;
	logic [KEY_WIDTH-1:0] best_val_q, ival_q;
	logic [BND_W-1:0]     low_q, high_q;
	logic [POS_W-1:0]     pos_q;
	logic                 found_q, status_q;

	logic                 full;
	logic [CNT_W-1:0]     i_inc, p_dec, mid_c, mid_dec;
	logic [BND_W:0]       mid_sum;
	logic                 rd_less, key_less;

	logic                 wr_en, rd_en;
	logic [IDX_W-1:0]     wr_addr, rd_addr;
	logic [KEY_WIDTH-1:0] wr_data;

	// sign-extend the input key, keep the table width
	assign key_ext = 64'(search_key);
	assign key_in  = key_ext[KEY_WIDTH-1:0];

	// index arithmetic
	assign full    = (count_q == CNT_W'(TABLE_DEPTH));
	assign i_inc   = i_q + CNT_W'(1);
	assign p_dec   = p_q - CNT_W'(1);
	assign mid_sum = {1'b0, low_q} + {1'b0, high_q};
	assign mid_c   = mid_sum[CNT_W:1];
	assign mid_dec = mid_c - CNT_W'(1);

	// signed key compares
	assign rd_less  = $signed(rd_data_q) < $signed(best_val_q);
	assign key_less = $signed(key_q) < $signed(rd_data_q);

	// status to controller
	always_comb begin
		stat.outer_go  = i_inc < count_q;
		stat.inner_go  = j_q < count_q;
		stat.need_swap = best_q != i_q;
		stat.lin_go    = p_q != '0;
		stat.lin_hit   = rd_data_q == key_q;
		stat.bin_go    = low_q <= high_q;
		stat.bin_hit   = rd_data_q == key_q;
	end

	// write port select
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = key_in;
		if (cmd.append) begin
			wr_en = !full;
		end else if (cmd.wr_swap1) begin
			wr_en   = 1'b1;
			wr_addr = i_q[IDX_W-1:0];
			wr_data = best_val_q;
		end else if (cmd.wr_swap2) begin
			wr_en   = 1'b1;
			wr_addr = best_q[IDX_W-1:0];
			wr_data = ival_q;
		end
	end

	// read port select
	always_comb begin
		rd_en   = cmd.rd_outer | cmd.rd_inner | cmd.rd_lin | cmd.rd_bin;
		rd_addr = i_q[IDX_W-1:0];
		if (cmd.rd_inner) begin
			rd_addr = j_q[IDX_W-1:0];
		end else if (cmd.rd_lin) begin
			rd_addr = p_dec[IDX_W-1:0];
		end else if (cmd.rd_bin) begin
			rd_addr = mid_dec[IDX_W-1:0];
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.append && !full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= key_in;
			i_q      <= '0;
			p_q      <= count_q;
			low_q    <= BND_W'(1);
			high_q   <= BND_W'(count_q);
			pos_q    <= '0;
			found_q  <= 1'b0;
			status_q <= cmd.append && full;
		end
		// sort: outer pass setup and inner scan
		if (cmd.init_inner) begin
			best_q     <= i_q;
			best_val_q <= rd_data_q;
			ival_q     <= rd_data_q;
			j_q        <= i_inc;
		end
		if (cmd.cmp_inner) begin
			if (rd_less) begin
				best_q     <= j_q;
				best_val_q <= rd_data_q;
			end
			j_q <= j_q + CNT_W'(1);
		end
		if (cmd.next_outer) begin
			i_q <= i_inc;
		end
		// sequential search walks down from the top
		if (cmd.cmp_lin) begin
			if (stat.lin_hit) begin
				pos_q   <= POS_W'(p_q);
				found_q <= 1'b1;
			end else begin
				p_q <= p_dec;
			end
		end
		// binary search probe
		if (cmd.rd_bin) begin
			mid_q <= mid_c;
		end
		if (cmd.cmp_bin) begin
			if (stat.bin_hit) begin
				pos_q   <= POS_W'(mid_q);
				found_q <= 1'b1;
			end else if (key_less) begin
				high_q <= BND_W'(mid_q) - BND_W'(1);
			end else begin
				low_q <= BND_W'(mid_q) + BND_W'(1);
			end
		end
	end

	assign position = pos_q;
	assign found    = found_q;
	assign status   = status_q;

endmodule

@@ hdl/stss_ctrl.sv @@
module stss_ctrl import stss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] action,
	input  stat_t      stat,
	output cmd_t       cmd,
	output logic       busy,
	output logic       done
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (action_t'(action))
						ACT_SORT:    state_d = ST_S_OUTER;
						ACT_LSEARCH: state_d = ST_L_CHK;
						ACT_BSEARCH: state_d = ST_B_CHK;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_S_OUTER: state_d = stat.outer_go ? ST_S_IWAIT : ST_DONE;
			ST_S_IWAIT: state_d = ST_S_JCHK;
			ST_S_JCHK: begin
				if (stat.inner_go) begin
					state_d = ST_S_JCMP;
				end else if (stat.need_swap) begin
					state_d = ST_S_SWAP1;
				end else begin
					state_d = ST_S_OUTER;
				end
			end
			ST_S_JCMP:  state_d = ST_S_JCHK;
			ST_S_SWAP1: state_d = ST_S_SWAP2;
			ST_S_SWAP2: state_d = ST_S_OUTER;
			ST_L_CHK:   state_d = stat.lin_go ? ST_L_CMP : ST_DONE;
			ST_L_CMP:   state_d = stat.lin_hit ? ST_DONE : ST_L_CHK;
			ST_B_CHK:   state_d = stat.bin_go ? ST_B_CMP : ST_DONE;
			ST_B_CMP:   state_d = stat.bin_hit ? ST_DONE : ST_B_CHK;
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (action_t'(action))
						ACT_CLEAR:  cmd.clear  = 1'b1;
						ACT_APPEND: cmd.append = 1'b1;
						default:    cmd.load   = 1'b1;
					endcase
				end
			end
			ST_S_OUTER: cmd.rd_outer   = stat.outer_go;
			ST_S_IWAIT: cmd.init_inner = 1'b1;
			ST_S_JCHK: begin
				cmd.rd_inner   = stat.inner_go;
				cmd.next_outer = !stat.inner_go && !stat.need_swap;
			end
			ST_S_JCMP:  cmd.cmp_inner = 1'b1;
			ST_S_SWAP1: cmd.wr_swap1  = 1'b1;
			ST_S_SWAP2: begin
				cmd.wr_swap2   = 1'b1;
				cmd.next_outer = 1'b1;
			end
			ST_L_CHK:   cmd.rd_lin  = stat.lin_go;
			ST_L_CMP:   cmd.cmp_lin = 1'b1;
			ST_B_CHK:   cmd.rd_bin  = stat.bin_go;
			ST_B_CMP:   cmd.cmp_bin = 1'b1;
			default:    cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

@@ hdl/static_table_sort_and_search.sv @@
// Search table of up to TABLE_DEPTH signed keys at positions 1..count. A
// transaction is taken when start is high and busy is low; its one result
// appears on position, found and status for a single cycle with done high,
// and the receiver must take it then. Clear, append and unknown actions
// go straight from idle to the result state. Each search probe is a read
// state then a compare state on the table's single registered read port.
// Sort does a full inner scan per position, one read per compare, then
// swaps where the minimum is not already in place.
// busy stays high until the result cycle is over.
module static_table_sort_and_search import stss_pkg::*; #(
	parameter int TABLE_DEPTH = 256,
	parameter int KEY_WIDTH   = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         action,
	input  logic signed [31:0] search_key,
	output logic               done,
	output logic [POS_W-1:0]   position,
	output logic               found,
	output logic               status
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	stss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// table, pointers and compares
	stss_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_WIDTH   (KEY_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.search_key (search_key),
		.stat       (stat),
		.position   (position),
		.found      (found),
		.status     (status)
	);

endmodule

@@ hdl/stss_checker.sv @@
module stss_checker import stss_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [POS_W-1:0] position,
	input logic             found,
	input logic             status
);

	// a result only shows while a transaction is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe outside a transaction");

	// an accepted transaction makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted transaction not busy");

	// busy only drops after a result was delivered
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done)) else $error("transaction ended without result");

	// a refused append carries no search result
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> !found && position == '0)
		else $error("refused append reports a position");

	// a miss reports position zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> position == '0) else $error("miss with nonzero position");

endmodule

bind static_table_sort_and_search stss_checker u_stss_checker (.*);

@@ tb/tb.sv @@
module tb;
	import stss_pkg::*;

	localparam int TABLE_DEPTH = 256;
	localparam int KEY_WIDTH   = 32;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int RANDOM_FILL_MAX = 20;
	localparam int END_SETTLE_CYCLES = 20;
	localparam logic [2:0] ACT_UNKNOWN_FIRST = 3'd5;
	localparam logic [2:0] ACT_UNKNOWN_LAST  = 3'd7;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             found;
		logic             status;
	} answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [2:0]         action = ACT_CLEAR;
	logic signed [31:0] search_key = '0;
	logic               busy;
	logic               done;
	logic [POS_W-1:0]   position;
	logic               found;
	logic               status;

	// mirror of the table contents, in table order
	logic signed [KEY_WIDTH-1:0] key_shadow [TABLE_DEPTH];
	int                          count_shadow = 0;
	answer_t                     awaited_answers [$];
	int                          error_count = 0;
	int                          cycle_count = 0;
	int                          idle_pct = 0;

	static_table_sort_and_search #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_WIDTH  (KEY_WIDTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.search_key(search_key),
		.done      (done),
		.position  (position),
		.found     (found),
		.status    (status)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// table behavior: apply one action to the mirror and give its answer
	function automatic answer_t run_table_action(input logic [2:0] act,
			input logic signed [31:0] key);
		int i;
		int j;
		int best;
		int lo;
		int hi;
		int mid;
		int pos;
		logic signed [KEY_WIDTH-1:0] tmp;
		answer_t ans;
		pos = 0;
		ans = '0;
		case (act)
			ACT_CLEAR: begin
				count_shadow = 0;
			end
			ACT_APPEND: begin
				if (count_shadow < TABLE_DEPTH) begin
					key_shadow[count_shadow] = key;
					count_shadow++;
				end else begin
					ans.status = 1'b1;
				end
			end
			ACT_SORT: begin
				// selection sort, first strict minimum wins
				for (i = 0; i + 1 < count_shadow; i++) begin
					best = i;
					for (j = i + 1; j < count_shadow; j++)
						if (key_shadow[j] < key_shadow[best])
							best = j;
					if (best != i) begin
						tmp = key_shadow[i];
						key_shadow[i] = key_shadow[best];
						key_shadow[best] = tmp;
					end
				end
			end
			ACT_LSEARCH: begin
				// highest matching position
				for (i = count_shadow; i > 0 && pos == 0; i--)
					if (key_shadow[i-1] == key)
						pos = i;
			end
			ACT_BSEARCH: begin
				lo = 1;
				hi = count_shadow;
				while (lo <= hi && pos == 0) begin
					mid = (lo + hi) / 2;
					if (key_shadow[mid-1] == key)
						pos = mid;
					else if (key < key_shadow[mid-1])
						hi = mid - 1;
					else
						lo = mid + 1;
				end
			end
			default: begin
			end
		endcase
		ans.position = pos[POS_W-1:0];
		ans.found = (pos != 0);
		return ans;
	endfunction

	// send one transaction, with an optional idle gap ahead of it
	task automatic issue_command(input logic [2:0] act, input logic signed [31:0] key);
		int gap;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(12, 1);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		search_key <= key;
		do @(posedge clk); while (busy);
		awaited_answers.push_back(run_table_action(act, key));
	endtask

	// hold off the sender until the table has answered everything
	task automatic wait_all_answers();
		start <= 1'b0;
		@(posedge clk);
		while (awaited_answers.size() != 0) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		answer_t want;
		if (arst_n && done) begin
			if (awaited_answers.size() == 0) begin
				$error("result with nothing pending: position %0d found %0b status %0b",
					position, found, status);
				error_count++;
			end else begin
				want = awaited_answers.pop_front();
				if (position !== want.position) begin
					$error("position mismatch: expected %0d, actual %0d",
						want.position, position);
					error_count++;
				end
				if (found !== want.found) begin
					$error("found mismatch: expected %0b, actual %0b", want.found, found);
					error_count++;
				end
				if (status !== want.status) begin
					$error("status mismatch: expected %0b, actual %0b", want.status, status);
					error_count++;
				end
			end
		end
	end

	// empty table, unknown actions, key extremes, duplicates, unsorted and sorted searches
	task automatic test_directed_cases();
		logic [2:0] a;
		idle_pct = 0;
		issue_command(ACT_LSEARCH, 32'sd0);
		issue_command(ACT_BSEARCH, 32'sd0);
		issue_command(ACT_SORT, 32'sd0);
		for (a = ACT_UNKNOWN_FIRST; a != ACT_CLEAR; a++)
			issue_command(a, 32'sh5A5A_A5A5);
		issue_command(ACT_APPEND, 32'sh7FFF_FFFF);
		issue_command(ACT_APPEND, 32'sh8000_0000);
		issue_command(ACT_APPEND, 32'sd0);
		issue_command(ACT_APPEND, -32'sd1);
		issue_command(ACT_APPEND, 32'sd5);
		issue_command(ACT_APPEND, 32'sd5);
		// probes on the unsorted table
		issue_command(ACT_BSEARCH, 32'sd5);
		issue_command(ACT_LSEARCH, 32'sd5);
		issue_command(ACT_LSEARCH, 32'sh8000_0000);
		issue_command(ACT_LSEARCH, 32'sd123);
		issue_command(ACT_SORT, 32'sd0);
		issue_command(ACT_BSEARCH, 32'sh8000_0000);
		issue_command(ACT_BSEARCH, 32'sh7FFF_FFFF);
		issue_command(ACT_BSEARCH, -32'sd1);
		issue_command(ACT_BSEARCH, 32'sd7);
		issue_command(ACT_CLEAR, 32'shFFFF_FFFF);
		issue_command(ACT_LSEARCH, 32'sd0);
		issue_command(ACT_BSEARCH, 32'sd0);
		wait_all_answers();
	endtask

	// fill to the last position, refused appends, full-size sort and searches
	task automatic test_full_table();
		int k;
		logic signed [31:0] probe;
		idle_pct = 26;
		issue_command(ACT_CLEAR, 32'sd0);
		for (k = 0; k < TABLE_DEPTH - 1; k++)
			issue_command(ACT_APPEND, ($urandom_range(1) != 0) ? $urandom
				: $urandom_range(31) - 16);
		issue_command(ACT_APPEND, 32'sh7FFF_FFFF);
		issue_command(ACT_APPEND, 32'sd42);
		issue_command(ACT_APPEND, $urandom);
		probe = key_shadow[$urandom_range(TABLE_DEPTH - 1)];
		issue_command(ACT_LSEARCH, probe);
		issue_command(ACT_BSEARCH, probe);
		issue_command(ACT_SORT, 32'sd0);
		issue_command(ACT_BSEARCH, 32'sh7FFF_FFFF);
		issue_command(ACT_BSEARCH, probe);
		issue_command(ACT_LSEARCH, key_shadow[0]);
		issue_command(ACT_BSEARCH, 32'sh7FFF_FFFE);
		issue_command(ACT_CLEAR, 32'sd0);
		wait_all_answers();
	endtask

	// mostly well-formed fill, sort and search sequences on small tables
	task automatic test_random_traffic(input int n_items, input int pct);
		int k;
		int pick;
		logic [2:0] act;
		logic signed [31:0] key;
		idle_pct = pct;
		for (k = 0; k < n_items; k++) begin
			pick = $urandom_range(99);
			if (pick < 4)
				act = ACT_CLEAR;
			else if (pick < 40)
				act = (count_shadow < RANDOM_FILL_MAX) ? ACT_APPEND : ACT_CLEAR;
			else if (pick < 50)
				act = ACT_SORT;
			else if (pick < 70)
				act = ACT_LSEARCH;
			else if (pick < 96)
				act = ACT_BSEARCH;
			else
				act = 3'($urandom_range(ACT_UNKNOWN_LAST, ACT_UNKNOWN_FIRST));
			// keys already stored, a small pool for duplicates, or anything
			case ($urandom_range(3))
				0, 1: key = (count_shadow > 0)
					? key_shadow[$urandom_range(count_shadow - 1)] : $urandom;
				2: key = $urandom_range(15) - 8;
				default: key = $urandom;
			endcase
			issue_command(act, key);
		end
		wait_all_answers();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_full_table();
		test_random_traffic(270, 0);
		test_random_traffic(270, 67);
		test_random_traffic(270, 26);
		test_random_traffic(240, 0);
		start <= 1'b0;
		while (awaited_answers.size() != 0) @(posedge clk);
		repeat (END_SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
